[rtl/mbx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_pkg: shared types and constants of the mail body extractor
// Character codes, the blank-line separator pattern and the queue entry that
// carries up to three normalized body bytes from the front to the back.
// ----------------------------------------------------------------------------
package mbx_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Length of the CR LF CR LF separator and the pattern itself.
	localparam int unsigned SEP_LEN = 4;
	localparam logic [SEP_LEN-1:0][7:0] SEP_PATTERN = {CH_LF, CH_CR, CH_LF, CH_CR};

	// Most body bytes one input transaction can produce.
	localparam int unsigned MAX_BYTES = 3;

	// Queue depth between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef logic [2:0] sep_prog_t;
	typedef logic [1:0] byte_cnt_t;

	// One queued group of body bytes; cnt is 1 to 3, bytes fill from index 0.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		byte_cnt_t                 cnt;
	} entry_t;

endpackage

[rtl/mbx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_front: line-ending normalizer and separator matcher
// Accepts one raw byte or end-of-message marker per cycle while the queue is
// not full, rewrites line endings as CR LF, tracks the blank-line separator
// and pushes the body bytes of each transaction into the queue as one entry.
// ----------------------------------------------------------------------------
module mbx_front
	import mbx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_eom,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	logic      pending_cr_q;
	sep_prog_t prog_q;
	logic      body_q;

	logic      pending_cr_d;
	sep_prog_t prog_d;
	logic      body_d;

	logic [MAX_BYTES-1:0][7:0] norm_bytes;
	byte_cnt_t                 norm_cnt;
	byte_cnt_t                 out_cnt;
	entry_t                    entry_d;
	logic                      accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Normalized byte sequence for a data byte, from the pending CR and the byte.
	always_comb begin
		norm_bytes[0] = (pending_cr_q || in_byte == CH_LF) ? CH_CR : in_byte;
		norm_bytes[1] = CH_LF;
		norm_bytes[2] = in_byte;
		pending_cr_d  = 1'b0;
		if (pending_cr_q) begin
			if (in_byte == CH_LF) begin
				norm_cnt = 2'd2;
			end else if (in_byte == CH_CR) begin
				norm_cnt     = 2'd2;
				pending_cr_d = 1'b1;
			end else begin
				norm_cnt = 2'd3;
			end
		end else begin
			if (in_byte == CH_CR) begin
				norm_cnt     = 2'd0;
				pending_cr_d = 1'b1;
			end else if (in_byte == CH_LF) begin
				norm_cnt = 2'd2;
			end else begin
				norm_cnt = 2'd1;
			end
		end
	end

	// Run the normalized bytes through the matcher; bytes after the separator go out.
	always_comb begin
		prog_d        = prog_q;
		body_d        = body_q;
		out_cnt       = 2'd0;
		entry_d.bytes = norm_bytes;
		if (in_eom) begin
			entry_d.bytes[0] = CH_CR;
			entry_d.bytes[1] = CH_LF;
			out_cnt          = (pending_cr_q && body_q) ? 2'd2 : 2'd0;
			prog_d           = '0;
			body_d           = 1'b0;
		end else begin
			for (int k = 0; k < MAX_BYTES; k++) begin
				if (byte_cnt_t'(k) < norm_cnt) begin
					if (body_d) begin
						entry_d.bytes[out_cnt] = norm_bytes[k];
						out_cnt                = out_cnt + 2'd1;
					end else if (norm_bytes[k] == SEP_PATTERN[prog_d[1:0]]) begin
						if (prog_d + 3'd1 >= sep_prog_t'(SEP_LEN)) begin
							prog_d = sep_prog_t'(SEP_LEN);
							body_d = 1'b1;
						end else begin
							prog_d = prog_d + 3'd1;
						end
					end else begin
						prog_d = (norm_bytes[k] == CH_CR) ? 3'd1 : 3'd0;
					end
				end
			end
		end
		entry_d.cnt = out_cnt;
	end

	assign q_push  = accept && (out_cnt != 2'd0);
	assign q_entry = entry_d;

	// Matcher state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_cr_q <= 1'b0;
			prog_q       <= '0;
			body_q       <= 1'b0;
		end else if (accept) begin
			pending_cr_q <= in_eom ? 1'b0 : pending_cr_d;
			prog_q       <= prog_d;
			body_q       <= body_d;
		end
	end

endmodule

[rtl/mbx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_queue: short entry queue between front and back
// A small register queue of byte groups; the front pushes, the back pops, and
// each side stalls only on full or empty.
// ----------------------------------------------------------------------------
module mbx_queue
	import mbx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/mbx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_back: body byte serializer
// Sends the bytes of the head queue entry one per transaction and marks the
// final byte of each entry, then releases the entry.
// ----------------------------------------------------------------------------
module mbx_back
	import mbx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	byte_cnt_t idx_q;
	logic      take;

	assign out_valid = !empty;
	assign out_byte  = head.bytes[idx_q];
	assign out_last  = (idx_q == head.cnt - 2'd1);
	assign take      = out_valid && out_ready;
	assign pop       = take && out_last;

	// Byte index within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= out_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[rtl/mail_body_extract_crlf_normalize_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mail_body_extract_crlf_normalize_unit: mail body extractor with CR LF fix-up
// Rewrites every line ending as CR LF, drops the header up to and including
// the blank line, and streams out the body bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction per raw byte in s_tdata with s_tuser=0,
//   or an end-of-message marker with s_tuser=1 that flushes a pending CR as
//   CR LF when the body has begun and returns the block to its reset state.
//   Output stream m_*: one body byte per transaction; m_tlast marks the final
//   byte produced by an input transaction. Transactions that produce nothing
//   give no output.
//   Latency: with the queue empty, the first byte of an input transaction
//   shows on m_* in the cycle after it is accepted; further bytes follow.
//   Throughput: one input transaction per cycle while the queue is not full;
//   an input that expands into two or three output bytes occupies the output
//   until all of them are sent, and the four-entry queue between matcher and
//   serializer absorbs the burst. s_tready drops only when that queue is full.
//   A stalled receiver holds m_* steady; input keeps flowing until the queue
//   fills. Reset clears the matcher state and empties the queue.
// ----------------------------------------------------------------------------
module mail_body_extract_crlf_normalize_unit
	import mbx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] opcode (1 = end of message)
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	entry_t q_in;
	entry_t q_head;

	// Normalizer and separator matcher.
	mbx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_eom   (s_tuser),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	// Decoupling queue.
	mbx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// Output serializer.
	mbx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
